@@ rtl/core/sample_variance_threshold_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Sample variance threshold unit: assertion macros
// Shared property macros; the including scope must provide clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_VARIANCE_THRESHOLD_UNIT_DEFINES_SVH
`define SAMPLE_VARIANCE_THRESHOLD_UNIT_DEFINES_SVH

// same-cycle implication
`define SVT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SVT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/svt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svt_pkg
// Widths, command and status types of the sample variance threshold unit.
// ----------------------------------------------------------------------------
package svt_pkg;

    localparam int MAX_SAMPLES_LOG2 = 20;
    localparam int SAMPLE_W         = 8;
    localparam int THR_W            = 16;
    localparam int CNT_W            = MAX_SAMPLES_LOG2 + 1;
    localparam int SUM_W            = MAX_SAMPLES_LOG2 + SAMPLE_W;
    localparam int SQ_W             = MAX_SAMPLES_LOG2 + 2 * SAMPLE_W;
    localparam int PROD_W           = THR_W + 2 * CNT_W;
    localparam int MPL_W            = (SUM_W > THR_W) ? SUM_W : THR_W;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(256);

    // products formed by the shared shift-add multiplier
    typedef enum logic [1:0] {
        OP_SQ,   // n * sumsq
        OP_SUM,  // sum * sum
        OP_CNT,  // n * (n - 1)
        OP_THR   // threshold * n * (n - 1)
    } mul_op_t;

    typedef struct packed {
        logic    accum;
        logic    load;
        mul_op_t load_op;
        logic    step;
        logic    capture;
        mul_op_t cap_op;
        logic    finish;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic few;
        logic out_free;
    } dp_status_t;

endpackage

@@ rtl/core/svt_sample_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svt_sample_if
// Sample stream channel: valid/ready with sample and frame end mark.
// ----------------------------------------------------------------------------
interface svt_sample_if;

    logic                         valid;
    logic                         ready;
    logic [svt_pkg::SAMPLE_W-1:0] sample;
    logic                         last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);

endinterface

@@ rtl/core/svt_result_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svt_result_if
// Result channel: valid/ready with the per-frame decision flags.
// ----------------------------------------------------------------------------
interface svt_result_if;

    logic valid;
    logic ready;
    logic varied;
    logic too_few;

    modport source (output valid, output varied, output too_few, input ready);
    modport sink   (input valid, input varied, input too_few, output ready);

endinterface

@@ rtl/core/svt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svt_ctrl
// Sequencer: accumulate phase, four shared-multiplier products, result write.
// ----------------------------------------------------------------------------
module svt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    svt_sample_if.sink          samples,
    input  svt_pkg::dp_status_t sts,
    output svt_pkg::dp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_MUL,
        S_DONE
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    svt_pkg::mul_op_t op_reg;
    svt_pkg::mul_op_t op_next;
    svt_pkg::mul_op_t op_succ;

    assign samples.ready = (state_reg == S_IDLE);

    always_comb
    begin
        unique case (op_reg)
            svt_pkg::OP_SQ:  op_succ = svt_pkg::OP_SUM;
            svt_pkg::OP_SUM: op_succ = svt_pkg::OP_CNT;
            svt_pkg::OP_CNT: op_succ = svt_pkg::OP_THR;
            svt_pkg::OP_THR: op_succ = svt_pkg::OP_SQ;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        cmd.accum     = 1'b0;
        cmd.load      = 1'b0;
        cmd.load_op   = svt_pkg::OP_SQ;
        cmd.step      = 1'b0;
        cmd.capture   = 1'b0;
        cmd.cap_op    = op_reg;
        cmd.finish    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (samples.valid)
                begin
                    cmd.accum = 1'b1;
                    if (samples.last)
                        state_next = S_START;
                end
            end
            S_START:
            begin
                if (sts.few)
                    state_next = S_DONE;
                else
                begin
                    cmd.load    = 1'b1;
                    cmd.load_op = svt_pkg::OP_SQ;
                    op_next     = svt_pkg::OP_SQ;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                if (sts.mul_done)
                begin
                    cmd.capture = 1'b1;
                    if (op_reg == svt_pkg::OP_THR)
                        state_next = S_DONE;
                    else
                    begin
                        cmd.load    = 1'b1;
                        cmd.load_op = op_succ;
                        op_next     = op_succ;
                    end
                end
                else
                    cmd.step = 1'b1;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= svt_pkg::OP_SQ;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

endmodule

@@ rtl/core/svt_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svt_dp
// Accumulators, threshold register, shift-add multiplier and result stage.
// ----------------------------------------------------------------------------
module svt_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [svt_pkg::SAMPLE_W-1:0] sample,
    input  logic                         cfg_wr_en,
    input  logic [svt_pkg::THR_W-1:0]    cfg_wr_data,
    input  svt_pkg::dp_cmd_t             cmd,
    output svt_pkg::dp_status_t          sts,
    svt_result_if.source                 result
);

    localparam int CNT_W  = svt_pkg::CNT_W;
    localparam int SUM_W  = svt_pkg::SUM_W;
    localparam int SQ_W   = svt_pkg::SQ_W;
    localparam int PROD_W = svt_pkg::PROD_W;
    localparam int MPL_W  = svt_pkg::MPL_W;
    localparam int THR_W  = svt_pkg::THR_W;
    localparam int SQR_W  = 2 * svt_pkg::SAMPLE_W;

    logic [CNT_W-1:0]  cnt_reg,      cnt_next;
    logic [SUM_W-1:0]  sum_reg,      sum_next;
    logic [SQ_W-1:0]   sq_reg,       sq_next;
    logic [THR_W-1:0]  thr_reg,      thr_next;
    logic [PROD_W-1:0] acc_reg,      acc_next;
    logic [PROD_W-1:0] mcand_reg,    mcand_next;
    logic [MPL_W-1:0]  mplier_reg,   mplier_next;
    logic [PROD_W-1:0] lhs_reg,      lhs_next;
    logic              varied_reg,   varied_next;
    logic              out_vld_reg,  out_vld_next;
    logic              out_var_reg,  out_var_next;
    logic              out_few_reg,  out_few_next;

    logic [SQR_W-1:0]  sample_sq;
    logic [CNT_W-1:0]  cnt_dec;
    logic [PROD_W-1:0] acc_step;

    assign sample_sq = SQR_W'(sample) * SQR_W'(sample);
    assign cnt_dec   = cnt_reg - CNT_W'(1);
    assign acc_step  = acc_reg + (mplier_reg[0] ? mcand_reg : '0);

    assign sts.mul_done = (mplier_reg == '0);
    assign sts.few      = (cnt_reg < CNT_W'(2));
    assign sts.out_free = !out_vld_reg || result.ready;

    assign result.valid   = out_vld_reg;
    assign result.varied  = out_var_reg;
    assign result.too_few = out_few_reg;

    always_comb
    begin
        cnt_next     = cnt_reg;
        sum_next     = sum_reg;
        sq_next      = sq_reg;
        thr_next     = thr_reg;
        acc_next     = acc_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        lhs_next     = lhs_reg;
        varied_next  = varied_reg;
        out_vld_next = out_vld_reg;
        out_var_next = out_var_reg;
        out_few_next = out_few_reg;

        if (cfg_wr_en)
            thr_next = cfg_wr_data;

        // count saturates at the cap; later samples are dropped
        if (cmd.accum && !cnt_reg[CNT_W-1])
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            sum_next = sum_reg + SUM_W'(sample);
            sq_next  = sq_reg + SQ_W'(sample_sq);
        end

        if (cmd.step)
        begin
            acc_next    = acc_step;
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
        end

        if (cmd.capture)
        begin
            unique case (cmd.cap_op)
                svt_pkg::OP_SQ:  lhs_next    = acc_reg;
                svt_pkg::OP_SUM: lhs_next    = lhs_reg - acc_reg;
                svt_pkg::OP_CNT: lhs_next    = lhs_reg;
                svt_pkg::OP_THR: varied_next = (lhs_reg > acc_reg);
            endcase
        end

        if (cmd.load)
        begin
            acc_next = '0;
            unique case (cmd.load_op)
                svt_pkg::OP_SQ:
                begin
                    mcand_next  = PROD_W'(sq_reg);
                    mplier_next = MPL_W'(cnt_reg);
                end
                svt_pkg::OP_SUM:
                begin
                    mcand_next  = PROD_W'(sum_reg);
                    mplier_next = MPL_W'(sum_reg);
                end
                svt_pkg::OP_CNT:
                begin
                    mcand_next  = PROD_W'(cnt_dec);
                    mplier_next = MPL_W'(cnt_reg);
                end
                svt_pkg::OP_THR:
                begin
                    mcand_next  = acc_reg;
                    mplier_next = MPL_W'(thr_reg);
                end
            endcase
        end

        if (result.ready)
            out_vld_next = 1'b0;

        if (cmd.finish)
        begin
            out_vld_next = 1'b1;
            out_var_next = !sts.few && varied_reg;
            out_few_next = sts.few;
            cnt_next     = '0;
            sum_next     = '0;
            sq_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            sum_reg     <= '0;
            sq_reg      <= '0;
            thr_reg     <= svt_pkg::THR_RESET;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            sum_reg     <= sum_next;
            sq_reg      <= sq_next;
            thr_reg     <= thr_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        lhs_reg     <= lhs_next;
        varied_reg  <= varied_next;
        out_var_reg <= out_var_next;
        out_few_reg <= out_few_next;
    end

endmodule

@@ rtl/core/sample_variance_threshold_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_variance_threshold_unit
// Per-frame sample variance test: n*sumsq - sum^2 > threshold*n*(n-1).
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  samples   in   valid/ready   sample[7:0], last
//  result    out  valid/ready   varied, too_few
//  cfg       in   cfg_wr_en     cfg_wr_data[15:0] (variance threshold)
//
//  Non-last samples: one transfer per cycle.
//  Last sample: input held off while one shift-add multiplier forms four
//  products, one multiplier bit per cycle; a frame of fewer than two
//  samples skips the products. A result waiting on the output stalls only
//  the end of the next frame.
//  Reset: accumulators zero, threshold 256, result channel empty.
// ----------------------------------------------------------------------------
`include "sample_variance_threshold_unit_defines.svh"

module sample_variance_threshold_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    svt_sample_if.sink                samples,
    svt_result_if.source              result,
    input  logic                      cfg_wr_en,
    input  logic [svt_pkg::THR_W-1:0] cfg_wr_data
);

    svt_pkg::dp_cmd_t    ctl_cmd;
    svt_pkg::dp_status_t dp_sts;

    svt_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .sts     (dp_sts),
        .cmd     (ctl_cmd)
    );

    svt_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (samples.sample),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (ctl_cmd),
        .sts         (dp_sts),
        .result      (result)
    );

    `SVT_ASSERT_NOW(a_no_take_while_mul, ctl_cmd.step, !samples.ready, "sample taken during multiply")
    `SVT_ASSERT_NOW(a_finish_slot_free, ctl_cmd.finish, dp_sts.out_free, "result overwrote pending result")
    `SVT_ASSERT_NOW(a_flags_exclusive, result.valid, !(result.varied && result.too_few), "varied with too_few")
    `SVT_ASSERT_NEXT(a_last_blocks_input, samples.valid && samples.ready && samples.last, !samples.ready, "input open after frame end")

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives sample frames into sample_variance_threshold_unit with random gaps
// and output stalls, and checks each frame decision against a cycle-free
// model of the count, sum and sum-of-squares variance test. A short directed
// table comes first, then random frames under several thresholds.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SAMPLE_W     = svt_pkg::SAMPLE_W;
    localparam int THR_W        = svt_pkg::THR_W;
    localparam int CNT_W        = svt_pkg::CNT_W;
    localparam int SUM_W        = svt_pkg::SUM_W;
    localparam int SQ_W         = svt_pkg::SQ_W;
    localparam int SAMPLE_CAP   = 1 << svt_pkg::MAX_SAMPLES_LOG2;
    localparam int SCRIPT_LEN   = 25;
    localparam int PHASE_ITEMS  = 182;
    localparam int FLUSH_CYCLES = 100;
    localparam int STALL_LIMIT  = 2000;

    typedef struct packed {
        logic varied;
        logic too_few;
    } frame_flags_t;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_CONFIG
    } row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        logic [SAMPLE_W-1:0] sample;
        logic                last;
        logic                known;
        frame_flags_t        flags;
        logic [THR_W-1:0]    threshold;
    } script_row_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [THR_W-1:0] cfg_wr_data;

    svt_sample_if samples_ch ();
    svt_result_if result_ch ();

    sample_variance_threshold_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (samples_ch),
        .result      (result_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    logic [CNT_W-1:0] model_count;
    logic [SUM_W-1:0] model_sum;
    logic [SQ_W-1:0]  model_sqsum;
    logic [THR_W-1:0] model_threshold;

    frame_flags_t pending_flags [$];
    int error_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        error_count++;
    endtask

    // Accumulate one sample; on the frame end, form the decision and clear.
    function automatic bit update_variance_model(input logic [SAMPLE_W-1:0] value,
                                                 input logic is_last,
                                                 output frame_flags_t flags);
        logic [63:0] n;
        logic [63:0] spread;
        logic [63:0] bound;
        flags = '0;
        if (model_count < SAMPLE_CAP)
        begin
            model_count = model_count + 1'b1;
            model_sum   = model_sum + SUM_W'(value);
            model_sqsum = model_sqsum + SQ_W'(value) * SQ_W'(value);
        end
        if (!is_last)
            return 1'b0;
        n = 64'(model_count);
        if (n < 2)
        begin
            flags.varied  = 1'b0;
            flags.too_few = 1'b1;
        end
        else
        begin
            spread = n * 64'(model_sqsum) - 64'(model_sum) * 64'(model_sum);
            bound  = 64'(model_threshold) * n * (n - 1);
            flags.varied  = (spread > bound);
            flags.too_few = 1'b0;
        end
        model_count = '0;
        model_sum   = '0;
        model_sqsum = '0;
        return 1'b1;
    endfunction

    function automatic script_row_t sample_row(input int value, input bit is_last);
        script_row_t row;
        row = '0;
        row.kind   = ROW_SAMPLE;
        row.sample = SAMPLE_W'(value);
        row.last   = is_last;
        return row;
    endfunction

    function automatic script_row_t known_row(input int value, input bit varied,
                                              input bit too_few);
        script_row_t row;
        row = sample_row(value, 1'b1);
        row.known         = 1'b1;
        row.flags.varied  = varied;
        row.flags.too_few = too_few;
        return row;
    endfunction

    function automatic script_row_t threshold_row(input int value);
        script_row_t row;
        row = '0;
        row.kind      = ROW_CONFIG;
        row.threshold = THR_W'(value);
        return row;
    endfunction

    // Called at the edge of the previous transfer or of a pause.
    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic is_last,
                               input int gap, input bit known,
                               input frame_flags_t known_flags);
        frame_flags_t predicted;
        if (gap > 0)
        begin
            samples_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples_ch.valid  <= 1'b1;
        samples_ch.sample <= value;
        samples_ch.last   <= is_last;
        @(posedge clk);
        while (!samples_ch.ready)
            @(posedge clk);
        if (update_variance_model(value, is_last, predicted))
            pending_flags.push_back(known ? known_flags : predicted);
    endtask

    task automatic drain(input int settle);
        samples_ch.valid <= 1'b0;
        while (pending_flags.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_threshold(input logic [THR_W-1:0] value);
        drain(FLUSH_CYCLES);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        model_threshold = value;
    endtask

    initial
    begin : result_sink
        int hold;
        int steady_left;
        frame_flags_t want;
        hold = 0;
        steady_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                if (pending_flags.size() == 0)
                    report_mismatch("result transfer with no frame end pending");
                else
                begin
                    want = pending_flags.pop_front();
                    if (result_ch.varied !== want.varied)
                        report_mismatch($sformatf("varied %b, expected %b",
                                                  result_ch.varied, want.varied));
                    if (result_ch.too_few !== want.too_few)
                        report_mismatch($sformatf("too_few %b, expected %b",
                                                  result_ch.too_few, want.too_few));
                end
                if (steady_left > 0)
                begin
                    steady_left--;
                    hold = 0;
                end
                else if ($urandom_range(0, 15) == 0)
                begin
                    steady_left = 20;
                    hold = 0;
                end
                else
                    hold = $urandom_range(0, 10);
            end
            if (hold > 0)
            begin
                result_ch.ready <= 1'b0;
                hold--;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((samples_ch.valid && samples_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("ERROR at %0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        script_row_t directed_script [SCRIPT_LEN];
        int frame_len;
        int center;
        int spread;
        int value;
        int filled;
        int pick;
        bit steady;
        logic [THR_W-1:0] thr;

        rst_n             <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_wr_data       <= '0;
        samples_ch.valid  <= 1'b0;
        samples_ch.sample <= '0;
        samples_ch.last   <= 1'b0;
        model_count       = '0;
        model_sum         = '0;
        model_sqsum       = '0;
        model_threshold   = svt_pkg::THR_RESET;

        directed_script = '{
            known_row(7, 1'b0, 1'b1),
            sample_row(0, 1'b0),    known_row(255, 1'b1, 1'b0),
            sample_row(255, 1'b0),  known_row(255, 1'b0, 1'b0),
            sample_row(10, 1'b0),   sample_row(32, 1'b1),
            sample_row(10, 1'b0),   sample_row(33, 1'b1),
            threshold_row(2),
            sample_row(0, 1'b0),    sample_row(2, 1'b1),
            sample_row(0, 1'b0),    sample_row(3, 1'b1),
            threshold_row(65535),
            sample_row(0, 1'b0),    sample_row(255, 1'b0),
            sample_row(0, 1'b0),    known_row(255, 1'b0, 1'b0),
            known_row(128, 1'b0, 1'b1),
            threshold_row(0),
            sample_row(77, 1'b0),   known_row(77, 1'b0, 1'b0),
            sample_row(77, 1'b0),   known_row(78, 1'b1, 1'b0)
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_script[i])
        begin
            if (directed_script[i].kind == ROW_CONFIG)
                set_threshold(directed_script[i].threshold);
            else
                send_sample(directed_script[i].sample, directed_script[i].last,
                            $urandom_range(0, 10), directed_script[i].known,
                            directed_script[i].flags);
        end

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: thr = 16'd1;
                1: thr = THR_W'($urandom_range(0, 65535));
                2: thr = THR_W'($urandom_range(50, 600));
                3: thr = 16'hFFFF;
                4: thr = THR_W'($urandom_range(600, 4000));
                default: thr = 16'd0;
            endcase
            set_threshold(thr);
            filled = 0;
            while (filled < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 15);
                if (pick == 0)
                    frame_len = 1;
                else if (pick <= 2)
                    frame_len = $urandom_range(30, 80);
                else
                    frame_len = $urandom_range(2, 12);
                center = $urandom_range(0, 255);
                case ($urandom_range(0, 4))
                    0: spread = 0;
                    1: spread = 3;
                    2: spread = 20;
                    3: spread = 60;
                    default: spread = 255;
                endcase
                steady = ($urandom_range(0, 3) == 0);
                for (int k = 0; k < frame_len; k++)
                begin
                    value = center + int'($urandom_range(0, 2 * spread)) - spread;
                    if (value < 0)
                        value = 0;
                    if (value > 255)
                        value = 255;
                    send_sample(SAMPLE_W'(value), k == frame_len - 1,
                                steady ? 0 : $urandom_range(0, 10), 1'b0, '0);
                end
                filled += frame_len;
                if ($urandom_range(0, 39) == 0)
                    drain(1);
            end
        end

        drain(FLUSH_CYCLES);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ sample_variance_threshold_unit.f @@
+incdir+rtl/core
rtl/core/svt_pkg.sv
rtl/core/svt_sample_if.sv
rtl/core/svt_result_if.sv
rtl/core/svt_ctrl.sv
rtl/core/svt_dp.sv
rtl/core/sample_variance_threshold_unit.sv
test/testbench.sv
